// ===== rtl/spf_pkg.sv =====
`default_nettype none
package spf_pkg;

	localparam int WORK_FRAC = 30;
	localparam logic signed [63:0] INT_LIM = 64'sd1 <<< 62;
	localparam logic signed [63:0] WONE = 64'sd1 <<< WORK_FRAC;
	localparam logic [5:0] TERM_COUNT_RESET = 6'd16;

	typedef struct packed {
		logic start;
		logic use_frac;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] num;
		logic [30:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [63:0] value;
	} unit_rsp_t;

	function automatic logic signed [63:0] clamp_lim(input logic signed [64:0] v);
		logic signed [64:0] lim;
		lim = {INT_LIM[63], INT_LIM};
		if (v > lim) begin
			return INT_LIM;
		end else if (v < -lim) begin
			return -INT_LIM;
		end
		return v[63:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/spf_if.sv =====
`default_nettype none
interface spf_operand_if;
	logic valid;
	logic ready;
	logic [30:0] base_value;
	logic signed [31:0] exponent_value;
	modport source(output valid, base_value, exponent_value, input ready);
	modport sink(input valid, base_value, exponent_value, output ready);
endinterface

interface spf_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] power_result;
	logic domain_error;
	logic saturated;
	modport source(output valid, power_result, domain_error, saturated, input ready);
	modport sink(input valid, power_result, domain_error, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/spf_mul.sv =====
`default_nettype none
module spf_mul #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  spf_pkg::mul_req_t    req,
	output spf_pkg::unit_rsp_t   rsp
);
	import spf_pkg::*;

	logic active_q, neg_q, frac_q, done_q;
	logic [2:0] ph_q;
	logic [1:0] idx_q;
	logic [63:0] a_mag_q, b_mag_q, pp_q;
	logic [127:0] acc_q;
	logic signed [63:0] value_q;

	logic [31:0] a_half, b_half;
	logic [127:0] pp_shifted, shifted;
	logic [63:0] mag;
	logic over;

	always_comb begin
		a_half = ph_q[1] ? a_mag_q[63:32] : a_mag_q[31:0];
		b_half = ph_q[0] ? b_mag_q[63:32] : b_mag_q[31:0];
		case (idx_q)
			2'd0: pp_shifted = {64'd0, pp_q};
			2'd3: pp_shifted = {pp_q, 64'd0};
			default: pp_shifted = {32'd0, pp_q, 32'd0};
		endcase
		shifted = frac_q ? (acc_q >> FRAC_BITS) : (acc_q >> WORK_FRAC);
		over = (shifted[127:64] != '0) || (shifted[63:0] > 64'(INT_LIM));
		mag = over ? 64'(INT_LIM) : shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			ph_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				ph_q <= '0;
			end else if (active_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd5) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_mag_q <= req.a[63] ? 64'(-req.a) : 64'(req.a);
			b_mag_q <= req.b[63] ? 64'(-req.b) : 64'(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			frac_q <= req.use_frac;
			acc_q <= '0;
		end else if (active_q) begin
			if (ph_q < 3'd4) begin
				pp_q <= 64'(a_half) * 64'(b_half);
				idx_q <= ph_q[1:0];
			end
			if (ph_q >= 3'd1 && ph_q <= 3'd4) begin
				acc_q <= acc_q + pp_shifted;
			end
			if (ph_q == 3'd5) begin
				value_q <= neg_q ? -$signed(mag) : $signed(mag);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.value = value_q;
endmodule
`default_nettype wire

// ===== rtl/spf_div.sv =====
`default_nettype none
module spf_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  spf_pkg::div_req_t    req,
	output spf_pkg::unit_rsp_t   rsp
);
	import spf_pkg::*;

	logic active_q, done_q, neg_q;
	logic [5:0] cnt_q;
	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [30:0] den_q;
	logic [31:0] trial;
	logic ge;

	always_comb begin
		trial = {rem_q[30:0], num_q[63]};
		ge = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num[63] ? 64'(-req.num) : 64'(req.num);
			neg_q <= req.num[63];
			den_q <= req.den;
			rem_q <= '0;
		end else if (active_q) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			num_q <= {num_q[62:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.value = neg_q ? -$signed(num_q) : $signed(num_q);
endmodule
`default_nettype wire

// ===== rtl/series_power_function.sv =====
// Power function a^x on Q16.16 operands: ln(a) from the series of ((a-1)/a)^k/k,
// then e^(x ln a) from its Taylor series, both with term_count terms (0 runs as 1,
// values above MAX_TERMS run as MAX_TERMS). A base below 0.5 returns zero with
// domain_error set; an out-of-range result saturates and sets saturated.
// One item at a time, all arithmetic on one 64-bit radix-2 divider and one 32x32
// partial-product multiplier; a domain error skips the arithmetic. The operand side
// is ready only between items; a finished result waits in the output register.
`default_nettype none
module series_power_function #(
	parameter int MAX_TERMS = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	spf_operand_if.sink      operand,
	spf_result_if.source     result,
	input  wire logic        term_count_we,
	input  wire logic [5:0]  term_count
);
	import spf_pkg::*;

	localparam int KW = $clog2(MAX_TERMS + 1);
	localparam int SH = WORK_FRAC - FRAC_BITS;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [64:0] BIAS = (65'sd1 <<< SH) - 65'sd1;

	typedef enum logic [2:0] {
		S_IDLE, S_UDIV, S_LNDIV, S_LNMUL, S_YMUL, S_EMUL, S_EDIV, S_FINISH
	} state_t;

	state_t state_q;
	logic [5:0] tc_q;
	logic [KW-1:0] n_q, k_q, n_next, k_inc;
	logic signed [63:0] u_q, p_q, lnv_q, y_q, sum_q, lnv_new, sum_new;
	logic signed [31:0] expo_q;
	logic err_q, out_valid_q, out_err_q, out_sat_q;
	logic signed [31:0] out_res_q;
	mul_req_t mreq_q;
	div_req_t dreq_q;
	unit_rsp_t mrsp, drsp;

	logic signed [64:0] biased, res65;
	logic signed [31:0] res32;
	logic res_sat;

	spf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq_q), .rsp(mrsp)
	);

	spf_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq_q), .rsp(drsp)
	);

	always_comb begin
		if (tc_q == '0) begin
			n_next = KW'(1);
		end else if (int'(tc_q) > MAX_TERMS) begin
			n_next = KW'(MAX_TERMS);
		end else begin
			n_next = KW'(tc_q);
		end
		k_inc = KW'(k_q + 1'b1);
		lnv_new = clamp_lim({lnv_q[63], lnv_q} + {drsp.value[63], drsp.value});
		sum_new = clamp_lim({sum_q[63], sum_q} + {drsp.value[63], drsp.value});
		biased = {sum_q[63], sum_q} + (sum_q[63] ? BIAS : 65'sd0);
		res65 = biased >>> SH;
		res_sat = 1'b0;
		if (res65 > 65'sd2147483647) begin
			res32 = 32'sh7fffffff;
			res_sat = 1'b1;
		end else if (res65 < -65'sd2147483648) begin
			res32 = 32'sh80000000;
			res_sat = 1'b1;
		end else begin
			res32 = res65[31:0];
		end
	end

	assign operand.ready = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.power_result = out_res_q;
	assign result.domain_error = out_err_q;
	assign result.saturated = out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= TERM_COUNT_RESET;
		end else if (term_count_we) begin
			tc_q <= term_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			mreq_q <= '0;
			dreq_q <= '0;
		end else begin
			mreq_q.start <= 1'b0;
			dreq_q.start <= 1'b0;
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (operand.valid) begin
						n_q <= n_next;
						expo_q <= operand.exponent_value;
						if ($signed({33'd0, operand.base_value}) < (ONE >>> 1)) begin
							err_q <= 1'b1;
							state_q <= S_FINISH;
						end else begin
							err_q <= 1'b0;
							dreq_q.start <= 1'b1;
							dreq_q.num <= ($signed({33'd0, operand.base_value}) - ONE)
								<<< WORK_FRAC;
							dreq_q.den <= operand.base_value;
							state_q <= S_UDIV;
						end
					end
				end
				S_UDIV: begin
					if (drsp.done) begin
						u_q <= drsp.value;
						p_q <= drsp.value;
						lnv_q <= '0;
						k_q <= KW'(1);
						dreq_q.start <= 1'b1;
						dreq_q.num <= drsp.value;
						dreq_q.den <= 31'd1;
						state_q <= S_LNDIV;
					end
				end
				S_LNDIV: begin
					if (drsp.done) begin
						lnv_q <= lnv_new;
						mreq_q.start <= 1'b1;
						if (k_q == n_q) begin
							mreq_q.a <= 64'(expo_q);
							mreq_q.b <= lnv_new;
							mreq_q.use_frac <= 1'b1;
							state_q <= S_YMUL;
						end else begin
							mreq_q.a <= p_q;
							mreq_q.b <= u_q;
							mreq_q.use_frac <= 1'b0;
							state_q <= S_LNMUL;
						end
					end
				end
				S_LNMUL: begin
					if (mrsp.done) begin
						p_q <= mrsp.value;
						k_q <= k_inc;
						dreq_q.start <= 1'b1;
						dreq_q.num <= mrsp.value;
						dreq_q.den <= 31'(k_inc);
						state_q <= S_LNDIV;
					end
				end
				S_YMUL: begin
					if (mrsp.done) begin
						y_q <= mrsp.value;
						sum_q <= WONE;
						k_q <= KW'(1);
						if (n_q == KW'(1)) begin
							state_q <= S_FINISH;
						end else begin
							mreq_q.start <= 1'b1;
							mreq_q.a <= WONE;
							mreq_q.b <= mrsp.value;
							mreq_q.use_frac <= 1'b0;
							state_q <= S_EMUL;
						end
					end
				end
				S_EMUL: begin
					if (mrsp.done) begin
						dreq_q.start <= 1'b1;
						dreq_q.num <= mrsp.value;
						dreq_q.den <= 31'(k_q);
						state_q <= S_EDIV;
					end
				end
				S_EDIV: begin
					if (drsp.done) begin
						sum_q <= sum_new;
						if (k_inc == n_q) begin
							state_q <= S_FINISH;
						end else begin
							k_q <= k_inc;
							mreq_q.start <= 1'b1;
							mreq_q.a <= drsp.value;
							mreq_q.b <= y_q;
							mreq_q.use_frac <= 1'b0;
							state_q <= S_EMUL;
						end
					end
				end
				S_FINISH: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_err_q <= err_q;
						out_res_q <= err_q ? 32'sd0 : res32;
						out_sat_q <= err_q ? 1'b0 : res_sat;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq_q.start && dreq_q.start))
		else $error("multiplier and divider started together");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.domain_error) |-> (result.power_result == 32'sd0 &&
		!result.saturated))
		else $error("domain error with nonzero result");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LNDIV || state_q == S_EDIV) |-> (k_q <= n_q && k_q != '0))
		else $error("term index out of range");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid &&
		$stable(result.power_result)))
		else $error("result changed while waiting");
endmodule
`default_nettype wire

// ===== bench/series_power_function_checker.sv =====
`default_nettype none
module series_power_function_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	spf_operand_if          operand,
	spf_result_if           result,
	input  wire logic       term_count_we,
	input  wire logic [5:0] term_count,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import spf_pkg::*;

	localparam int TERM_MAX = 32;
	localparam logic [63:0] LIM_MAG = 64'h4000_0000_0000_0000;

	typedef struct {
		logic signed [31:0] power;
		logic               domain;
		logic               clipped;
	} power_t;

	power_t     expected_powers[$];
	logic [5:0] term_setting;

	// (a*b) >> s with truncation toward zero, magnitude clamped
	function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
		input logic signed [63:0] b, input int s);
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [127:0] prod;
		logic [63:0]  mag;
		logic         neg;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		prod = {64'd0, ma} * {64'd0, mb};
		prod = prod >> s;
		mag = (prod > {64'd0, LIM_MAG}) ? LIM_MAG : prod[63:0];
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [63:0] limit_sum(input logic signed [64:0] v);
		if (v > $signed({1'b0, LIM_MAG})) begin
			return $signed(LIM_MAG);
		end else if (v < -$signed({1'b0, LIM_MAG})) begin
			return -$signed(LIM_MAG);
		end
		return v[63:0];
	endfunction

	function automatic power_t predict_power(input logic [30:0] base,
		input logic signed [31:0] expo, input logic [5:0] setting);
		power_t             r;
		longint             n;
		longint             k;
		logic signed [63:0] b64;
		logic signed [63:0] u;
		logic signed [63:0] p;
		logic signed [63:0] lnv;
		logic signed [63:0] y;
		logic signed [63:0] t;
		logic signed [63:0] sum;
		logic signed [63:0] q;
		logic signed [64:0] wide;
		n = setting;
		if (n < 1) n = 1;
		if (n > TERM_MAX) n = TERM_MAX;
		r.power = 0;
		r.domain = 0;
		r.clipped = 0;
		if (base < 31'd32768) begin
			r.domain = 1;
			return r;
		end
		b64 = $signed({33'd0, base});
		u = ((b64 - 64'sd65536) * WONE) / b64;
		lnv = 0;
		p = u;
		for (k = 1; k <= n; k++) begin
			wide = lnv;
			wide = wide + (p / k);
			lnv = limit_sum(wide);
			p = scaled_product(p, u, WORK_FRAC);
		end
		y = scaled_product({{32{expo[31]}}, expo}, lnv, 16);
		sum = WONE;
		t = WONE;
		for (k = 1; k < n; k++) begin
			t = scaled_product(t, y, WORK_FRAC) / k;
			wide = sum;
			wide = wide + t;
			sum = limit_sum(wide);
		end
		q = sum / 64'sd16384;
		if (q > 64'sd2147483647) begin
			r.power = 32'h7fff_ffff;
			r.clipped = 1;
		end else if (q < -64'sd2147483648) begin
			r.power = 32'h8000_0000;
			r.clipped = 1;
		end else begin
			r.power = q[31:0];
		end
		return r;
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = expected_powers.size();

	always @(posedge clk or negedge arst_n) begin
		power_t e;
		if (!arst_n) begin
			term_setting <= TERM_COUNT_RESET;
		end else begin
			if (term_count_we) begin
				term_setting <= term_count;
			end
			if (operand.valid && operand.ready) begin
				expected_powers.push_back(predict_power(operand.base_value,
					operand.exponent_value, term_setting));
			end
			if (result.valid && result.ready) begin
				if (expected_powers.size() == 0) begin
					report("result transfer with nothing expected");
				end else begin
					e = expected_powers.pop_front();
					if (result.power_result !== e.power) begin
						report($sformatf("power_result %h, expected %h",
							result.power_result, e.power));
					end
					if (result.domain_error !== e.domain) begin
						report($sformatf("domain_error %b, expected %b",
							result.domain_error, e.domain));
					end
					if (result.saturated !== e.clipped) begin
						report($sformatf("saturated %b, expected %b",
							result.saturated, e.clipped));
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== bench/series_power_function_tb.sv =====
`default_nettype none
module series_power_function_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 30_000_000;
	localparam int ITEM_TARGET = 1550;

	logic       clk;
	logic       arst_n;
	logic       term_count_we;
	logic [5:0] term_count;
	logic       quiet;
	int         fail_count;
	int         pending;
	int         sent;
	longint     cycles;

	spf_operand_if operand_ch();
	spf_result_if  result_ch();

	series_power_function uut (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand_ch),
		.result(result_ch),
		.term_count_we(term_count_we),
		.term_count(term_count)
	);

	series_power_function_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand_ch),
		.result(result_ch),
		.term_count_we(term_count_we),
		.term_count(term_count),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// receiver stalls
	initial begin
		result_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				result_ch.ready = 0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			result_ch.ready = 1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
	end

	task automatic send_item(input logic [30:0] base, input logic [31:0] expo);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			operand_ch.valid = 0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		operand_ch.valid = 1;
		operand_ch.base_value = base;
		operand_ch.exponent_value = expo;
		@(posedge clk);
		while (!operand_ch.ready) @(posedge clk);
		@(negedge clk);
		sent++;
		if (sent > ITEM_TARGET - 150) quiet = 1;
	endtask

	task automatic set_terms(input logic [5:0] value);
		operand_ch.valid = 0;
		wait (pending == 0);
		repeat (8) @(negedge clk);
		term_count_we = 1;
		term_count = value;
		@(negedge clk);
		term_count_we = 0;
	endtask

	function automatic logic [30:0] pick_base();
		case ($urandom_range(0, 5))
			0: return 31'($urandom_range(0, 32767));
			1: return 31'($urandom);
			2: return 31'($urandom_range(32768, 65536 * 4));
			default: return 31'($urandom_range(40000, 100000));
		endcase
	endfunction

	function automatic logic [31:0] pick_exponent();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($urandom_range(0, 65536 * 8) - 65536 * 4);
			default: return 32'($urandom_range(0, 65536 * 2) - 65536);
		endcase
	endfunction

	initial begin
		logic [5:0] setting;
		int         phase;
		int         count;
		arst_n = 0;
		quiet = 0;
		sent = 0;
		term_count_we = 0;
		term_count = 0;
		operand_ch.valid = 0;
		operand_ch.base_value = 0;
		operand_ch.exponent_value = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed corners at the reset term count
		send_item(31'd0, 32'h0001_0000);
		send_item(31'd32767, 32'h0001_0000);
		send_item(31'd32768, 32'h0001_0000);
		send_item(31'd65536, 32'h7fff_ffff);
		send_item(31'h7fff_ffff, 32'h0000_0000);
		send_item(31'h7fff_ffff, 32'h7fff_ffff);
		send_item(31'h7fff_ffff, 32'h8000_0000);
		send_item(31'd32768, 32'h8000_0000);
		send_item(31'd32768, 32'h7fff_ffff);
		send_item(31'd131072, 32'h0002_0000);
		send_item(31'd131072, 32'hffff_0000);
		send_item(31'd98304, 32'hffff_ffff);
		send_item(31'd65537, 32'h0000_0001);
		send_item(31'h4000_0000, 32'h0001_0000);
		send_item(31'h5555_5555, 32'h2aaa_aaaa);
		send_item(31'h2aaa_aaaa, 32'hd555_5555);

		phase = 0;
		while (sent < ITEM_TARGET) begin
			case (phase)
				0: setting = 6'd0;
				1: setting = 6'd1;
				2: setting = 6'd63;
				3: setting = 6'd32;
				4: setting = 6'd33;
				5: setting = 6'd2;
				default: setting = ($urandom_range(0, 7) == 0) ?
					6'($urandom) : 6'($urandom_range(1, 8));
			endcase
			set_terms(setting);
			if (phase < 6) begin
				send_item(31'd32767, 32'h0001_0000);
				send_item(31'h7fff_ffff, 32'h7fff_ffff);
				send_item(31'd32768, 32'h8000_0000);
			end
			count = (setting > 12) ? 12 : 70;
			repeat (count) send_item(pick_base(), pick_exponent());
			phase++;
		end

		operand_ch.valid = 0;
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
